// File: rtl/chb_pkg.sv
// Package: constants, types and arctangent table for the compass heading pipeline.
`timescale 1ns / 1ps

package chb_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int NUM_ITER     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	localparam int FIELD_W   = 16;
	localparam int VEC_W     = 36;
	localparam int ANG_W     = 33;
	localparam int FRAC_BITS = 16;
	localparam int DEG_W     = 17;
	localparam int SUM_W     = 18;
	localparam int HEAD_W    = 16;

	localparam logic signed [ANG_W-1:0] HALF_TURN_Z = 33'sd1179648000;
	localparam logic signed [ANG_W-1:0] ROUND_HALF  = 33'sd32768;
	localparam logic signed [SUM_W:0]   FULL_TURN   = 19'sd36000;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} chb_vec_t;

	// atan(2^-i) in 1/65536 centidegree units
	function automatic logic signed [ANG_W-1:0] atan_units(input int idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			0:  r = 33'sd294912000;
			1:  r = 33'sd174096719;
			2:  r = 33'sd91987925;
			3:  r = 33'sd46694507;
			4:  r = 33'sd23437865;
			5:  r = 33'sd11730358;
			6:  r = 33'sd5866610;
			7:  r = 33'sd2933484;
			8:  r = 33'sd1466764;
			9:  r = 33'sd733385;
			10: r = 33'sd366693;
			11: r = 33'sd183346;
			12: r = 33'sd91673;
			13: r = 33'sd45837;
			14: r = 33'sd22918;
			15: r = 33'sd11459;
			16: r = 33'sd5730;
			17: r = 33'sd2865;
			18: r = 33'sd1432;
			19: r = 33'sd716;
			20: r = 33'sd358;
			21: r = 33'sd179;
			22: r = 33'sd90;
			23: r = 33'sd45;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/chb_pre.sv
// Input stage: folds the vector into the right half plane and seeds the angle.
`timescale 1ns / 1ps

module chb_pre (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_beat,
	input  logic signed [chb_pkg::FIELD_W-1:0]    field_x,
	input  logic signed [chb_pkg::FIELD_W-1:0]    field_y,
	output logic                                  valid,
	output chb_pkg::chb_vec_t                     vec
);

	logic signed [chb_pkg::FIELD_W:0] xe;
	logic signed [chb_pkg::FIELD_W:0] ye;
	logic signed [chb_pkg::FIELD_W:0] xf;
	logic signed [chb_pkg::FIELD_W:0] yf;
	chb_pkg::chb_vec_t                vec_d;
	logic                             valid_s1;
	chb_pkg::chb_vec_t                vec_s1;

	always_comb begin
		xe = {field_x[chb_pkg::FIELD_W-1], field_x};
		ye = {field_y[chb_pkg::FIELD_W-1], field_y};
		xf = field_x[chb_pkg::FIELD_W-1] ? -xe : xe;
		yf = field_x[chb_pkg::FIELD_W-1] ? -ye : ye;
		vec_d.x = {{(chb_pkg::VEC_W - chb_pkg::FIELD_W - 1 - chb_pkg::FRAC_BITS){xf[chb_pkg::FIELD_W]}},
			xf, {chb_pkg::FRAC_BITS{1'b0}}};
		vec_d.y = {{(chb_pkg::VEC_W - chb_pkg::FIELD_W - 1 - chb_pkg::FRAC_BITS){yf[chb_pkg::FIELD_W]}},
			yf, {chb_pkg::FRAC_BITS{1'b0}}};
		if (!field_x[chb_pkg::FIELD_W-1]) begin
			vec_d.z = '0;
		end else if (!field_y[chb_pkg::FIELD_W-1]) begin
			vec_d.z = chb_pkg::HALF_TURN_Z;
		end else begin
			vec_d.z = -chb_pkg::HALF_TURN_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec_d;
		end
	end

	assign valid = valid_s1;
	assign vec   = vec_s1;

endmodule

// File: rtl/chb_cordic.sv
// Unrolled vectoring CORDIC: one micro-rotation per pipeline stage.
`timescale 1ns / 1ps

module chb_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  chb_pkg::chb_vec_t  in_vec,
	output logic               valid,
	output chb_pkg::chb_vec_t  vec
);

	logic              valid_s2 [chb_pkg::NUM_ITER];
	chb_pkg::chb_vec_t vec_s2   [chb_pkg::NUM_ITER];

	genvar k;
	generate
		for (k = 0; k < chb_pkg::NUM_ITER; k++) begin : g_iter
			chb_pkg::chb_vec_t       cur;
			chb_pkg::chb_vec_t       nxt;
			logic                    vin;
			logic signed [chb_pkg::VEC_W-1:0] xs;
			logic signed [chb_pkg::VEC_W-1:0] ys;

			if (k == 0) begin : g_first
				assign cur = in_vec;
				assign vin = in_valid;
			end else begin : g_next
				assign cur = vec_s2[k-1];
				assign vin = valid_s2[k-1];
			end

			always_comb begin
				xs  = cur.x >>> k;
				ys  = cur.y >>> k;
				nxt = cur;
				// y exactly zero: vector and angle stay put
				if (cur.y != '0) begin
					if (!cur.y[chb_pkg::VEC_W-1]) begin
						nxt.x = cur.x + ys;
						nxt.y = cur.y - xs;
						nxt.z = cur.z + chb_pkg::atan_units(k);
					end else begin
						nxt.x = cur.x - ys;
						nxt.y = cur.y + xs;
						nxt.z = cur.z - chb_pkg::atan_units(k);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s2[k] <= 1'b0;
				end else if (en) begin
					valid_s2[k] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					vec_s2[k] <= nxt;
				end
			end
		end
	endgenerate

	assign valid = valid_s2[chb_pkg::NUM_ITER-1];
	assign vec   = vec_s2[chb_pkg::NUM_ITER-1];

endmodule

// File: rtl/chb_post.sv
// Back end: rounds the angle to centidegrees, adds declination, wraps into a full turn.
`timescale 1ns / 1ps

module chb_post (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic signed [chb_pkg::ANG_W-1:0]     z,
	input  logic signed [chb_pkg::FIELD_W-1:0]   decl,
	output logic                                 valid,
	output logic [chb_pkg::HEAD_W-1:0]           heading
);

	logic signed [chb_pkg::ANG_W-1:0] z_rnd;
	logic signed [chb_pkg::DEG_W-1:0] angle;
	logic signed [chb_pkg::SUM_W-1:0] sum_d;
	logic                             valid_s3;
	logic signed [chb_pkg::SUM_W-1:0] sum_s3;
	logic signed [chb_pkg::SUM_W:0]   hx;
	logic signed [chb_pkg::SUM_W:0]   wrap_d;
	logic                             valid_s4;
	logic [chb_pkg::HEAD_W-1:0]       heading_s4;

	always_comb begin
		z_rnd = z + chb_pkg::ROUND_HALF;
		angle = z_rnd[chb_pkg::ANG_W-1:chb_pkg::FRAC_BITS];
		sum_d = {angle[chb_pkg::DEG_W-1], angle}
			+ {{(chb_pkg::SUM_W - chb_pkg::FIELD_W){decl[chb_pkg::FIELD_W-1]}}, decl};
	end

	always_comb begin
		hx = {sum_s3[chb_pkg::SUM_W-1], sum_s3};
		if (hx >= chb_pkg::FULL_TURN) begin
			wrap_d = hx - chb_pkg::FULL_TURN;
		end else if (!hx[chb_pkg::SUM_W]) begin
			wrap_d = hx;
		end else if (hx >= -chb_pkg::FULL_TURN) begin
			wrap_d = hx + chb_pkg::FULL_TURN;
		end else begin
			wrap_d = hx + chb_pkg::FULL_TURN + chb_pkg::FULL_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3     <= sum_d;
			heading_s4 <= wrap_d[chb_pkg::HEAD_W-1:0];
		end
	end

	assign valid   = valid_s4;
	assign heading = heading_s4;

endmodule

// File: rtl/chb_out.sv
// Output register with skid entry; freezes the pipeline only when the skid entry is full.
`timescale 1ns / 1ps

module chb_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pipe_valid,
	input  logic [chb_pkg::HEAD_W-1:0]    pipe_heading,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [chb_pkg::HEAD_W-1:0]    heading,
	output logic                          en
);

	logic                         out_valid_q;
	logic                         skid_valid_q;
	logic [chb_pkg::HEAD_W-1:0]   out_q;
	logic [chb_pkg::HEAD_W-1:0]   skid_q;
	logic                         taken;
	logic                         load_out;
	logic                         load_skid;

	always_comb begin
		en        = !skid_valid_q;
		taken     = out_valid_q && !out_stall;
		load_out  = pipe_valid && en && (!out_valid_q || taken);
		load_skid = pipe_valid && en && out_valid_q && out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (taken && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (taken && !skid_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (taken && skid_valid_q) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= pipe_heading;
		end
		if (load_skid) begin
			skid_q <= pipe_heading;
		end
	end

	assign out_valid = out_valid_q;
	assign heading   = out_q;

endmodule

// File: rtl/compass_heading_from_xy.sv
// Top level: compass heading from X/Y magnetometer counts via a pipelined CORDIC.
`timescale 1ns / 1ps
// Usage:
//  Input channel: field_x, field_y (signed counts) with in_valid / in_stall. A beat is
//  taken on a rising edge with in_valid high and in_stall low.
//  Output channel: heading_centideg (0..35999) with out_valid / out_stall, same rule.
//  Config channel: declination_centideg with cfg_valid / cfg_ready; cfg_ready is always
//  high. Write it only while no beats are in flight.
//  Path: input beat to out_valid through 1 fold stage, 16 CORDIC stages,
//  2 rounding/wrap stages and 1 output register, one micro-rotation per CORDIC stage.
//  Throughput: one beat per cycle sustained while out_stall stays low.
//  Stall: the output register plus one skid entry absorb the first beat that arrives while stalled;
//  after that in_stall rises and the whole pipeline holds until the cycle after
//  out_stall drops. No beat is dropped or repeated.
//  Reset: arst_n clears all valid bits and sets declination to zero; no result is
//  presented until a new beat has gone through.
module compass_heading_from_xy (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [chb_pkg::FIELD_W-1:0]  field_x,
	input  logic signed [chb_pkg::FIELD_W-1:0]  field_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [chb_pkg::HEAD_W-1:0]          heading_centideg,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic signed [chb_pkg::FIELD_W-1:0]  declination_centideg
);

	logic                               en;
	logic                               in_beat;
	logic signed [chb_pkg::FIELD_W-1:0] decl_q;
	logic                               pre_valid;
	chb_pkg::chb_vec_t                  pre_vec;
	logic                               cor_valid;
	chb_pkg::chb_vec_t                  cor_vec;
	logic                               post_valid;
	logic [chb_pkg::HEAD_W-1:0]         post_heading;

	assign cfg_ready = 1'b1;
	assign in_stall  = !en;
	assign in_beat   = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			decl_q <= declination_centideg;
		end
	end

	chb_pre u_pre (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_beat (in_beat),
		.field_x (field_x),
		.field_y (field_y),
		.valid   (pre_valid),
		.vec     (pre_vec)
	);

	chb_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pre_valid),
		.in_vec   (pre_vec),
		.valid    (cor_valid),
		.vec      (cor_vec)
	);

	chb_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cor_valid),
		.z        (cor_vec.z),
		.decl     (decl_q),
		.valid    (post_valid),
		.heading  (post_heading)
	);

	chb_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.pipe_valid   (post_valid),
		.pipe_heading (post_heading),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.heading      (heading_centideg),
		.en           (en)
	);

endmodule

// File: rtl/chb_checker.sv
// Port-level checker for the compass heading block, bound to the top level.
`timescale 1ns / 1ps

module chb_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [chb_pkg::HEAD_W-1:0]         heading_centideg
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(heading_centideg))
		else $error("heading changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> heading_centideg < 16'd36000)
		else $error("heading out of range");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled output beat");

endmodule

bind compass_heading_from_xy chb_checker u_chb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.heading_centideg (heading_centideg)
);

// File: sim/tb_compass_heading_from_xy.sv
// Testbench: random and directed X/Y samples through the compass heading pipeline, self-checked.
`timescale 1ns / 1ps

module tb_compass_heading_from_xy;

	localparam int          PERIOD_HI   = 6;
	localparam int          PERIOD_LO   = 6;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          N_PHASES    = 10;
	localparam int          PHASE_BEATS = 220;
	localparam int          HOLD_PHASE  = 3;
	localparam int          HOLD_CYCLES = 400;
	localparam int          DRAIN_WAIT  = 40;
	localparam longint      HALF_TURN   = 64'sd18000 <<< 16;
	localparam longint      FULL_TURN   = 36000;

	// atan(2^-i) in 1/65536 centidegree
	localparam longint ATAN_STEP [24] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
		5866610, 2933484, 1466764, 733385, 366693, 183346,
		91673, 45837, 22918, 11459, 5730, 2865,
		1432, 716, 358, 179, 90, 45
	};

	typedef enum int {
		IDLE_NONE = 0,
		IDLE_SOME = 1,
		IDLE_FULL = 2
	} idle_mode_t;

	typedef struct {
		logic signed [chb_pkg::FIELD_W-1:0] x;
		logic signed [chb_pkg::FIELD_W-1:0] y;
		int                                 gap;
	} mag_sample_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	logic signed [chb_pkg::FIELD_W-1:0] field_x = '0;
	logic signed [chb_pkg::FIELD_W-1:0] field_y = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	logic [chb_pkg::HEAD_W-1:0]         heading_centideg;
	logic                               cfg_valid = 1'b0;
	logic                               cfg_ready;
	logic signed [chb_pkg::FIELD_W-1:0] declination_centideg = '0;

	mag_sample_t                samples_to_send [$];
	logic [chb_pkg::HEAD_W-1:0] headings_due [$];

	logic signed [chb_pkg::FIELD_W-1:0] decl_applied = '0;
	idle_mode_t                         send_mode = IDLE_NONE;
	idle_mode_t                         recv_mode = IDLE_NONE;
	int                                 phase_num = 0;
	int                                 send_wait = 0;
	int                                 recv_wait = 0;
	int                                 hold_left = 0;
	logic                               hold_done = 1'b0;
	int                                 errors = 0;
	int                                 beats_in = 0;
	int                                 beats_out = 0;
	int                                 decl_writes = 0;
	int unsigned                        cycles = 0;

	compass_heading_from_xy dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.field_x              (field_x),
		.field_y              (field_y),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.heading_centideg     (heading_centideg),
		.cfg_valid            (cfg_valid),
		.cfg_ready            (cfg_ready),
		.declination_centideg (declination_centideg)
	);

	always begin
		#PERIOD_LO clk = 1'b1;
		#PERIOD_HI clk = 1'b0;
	end

	function automatic logic [chb_pkg::HEAD_W-1:0] heading_of(
			logic signed [chb_pkg::FIELD_W-1:0] fx,
			logic signed [chb_pkg::FIELD_W-1:0] fy,
			logic signed [chb_pkg::FIELD_W-1:0] decl);
		longint vx, vy, ang, sx, sy, h;
		int     i;
		vx  = fx;
		vy  = fy;
		ang = 0;
		if (vx != 0 || vy != 0) begin
			if (vx < 0) begin
				ang = (vy >= 0) ? HALF_TURN : -HALF_TURN;
				vx  = -vx;
				vy  = -vy;
			end
			vx = vx * 65536;
			vy = vy * 65536;
			for (i = 0; i < chb_pkg::CORDIC_STEPS && i < 24; i++) begin
				sx = vx >>> i;
				sy = vy >>> i;
				if (vy > 0) begin
					vx  = vx + sy;
					vy  = vy - sx;
					ang = ang + ATAN_STEP[i];
				end else if (vy < 0) begin
					vx  = vx - sy;
					vy  = vy + sx;
					ang = ang - ATAN_STEP[i];
				end
			end
			ang = (ang + 32768) >>> 16;
		end
		h = (ang + longint'(decl)) % FULL_TURN;
		if (h < 0)
			h = h + FULL_TURN;
		return h[chb_pkg::HEAD_W-1:0];
	endfunction

	function automatic int draw_wait(idle_mode_t mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_SOME: return ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 18)) : 0;
			default:   return $urandom_range(0, 18);
		endcase
	endfunction

	function automatic mag_sample_t random_sample(idle_mode_t mode);
		mag_sample_t s;
		int          k, r;
		int          edge_vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
		k = $urandom_range(0, 99);
		if (k < 55) begin
			s.x = 16'($urandom);
			s.y = 16'($urandom);
		end else if (k < 70) begin
			s.x = 16'(int'($urandom_range(0, 8)) - 4);
			s.y = 16'(int'($urandom_range(0, 8)) - 4);
		end else if (k < 80) begin
			r = $urandom_range(0, 1);
			s.x = r ? 16'($urandom) : '0;
			s.y = r ? '0 : 16'($urandom);
		end else if (k < 88) begin
			s.x = 16'(edge_vals[$urandom_range(0, 5)]);
			s.y = 16'(edge_vals[$urandom_range(0, 5)]);
		end else if (k < 93) begin
			s.x = '0;
			s.y = '0;
		end else begin
			r = $urandom_range(1, 32767);
			s.x = $urandom_range(0, 1) ? 16'(r) : 16'(-r);
			r = r + int'($urandom_range(0, 2)) - 1;
			s.y = $urandom_range(0, 1) ? 16'(r) : 16'(-r);
		end
		s.gap = draw_wait(mode);
		return s;
	endfunction

	// sender: one beat per pending sample, random gap before each
	always @(posedge clk) begin : drive_samples
		mag_sample_t s;
		logic        nv;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				headings_due.push_back(heading_of(field_x, field_y, decl_applied));
				beats_in++;
			end
			if (!in_valid || !in_stall) begin
				nv = 1'b0;
				if (samples_to_send.size() != 0) begin
					if (send_wait < samples_to_send[0].gap) begin
						send_wait++;
					end else begin
						s = samples_to_send.pop_front();
						field_x <= s.x;
						field_y <= s.y;
						nv = 1'b1;
						send_wait = 0;
					end
				end
				in_valid <= nv;
			end
		end
	end

	// receiver: check each result beat, then stall for a random count
	always @(posedge clk) begin : check_headings
		logic [chb_pkg::HEAD_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (headings_due.size() == 0) begin
					$error("heading_centideg: expected none, actual %0d", heading_centideg);
					errors++;
				end else begin
					want = headings_due.pop_front();
					if (heading_centideg !== want) begin
						$error("heading_centideg: expected %0d, actual %0d", want,
							heading_centideg);
						errors++;
					end
				end
				beats_out++;
				recv_wait = draw_wait(recv_mode);
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// long output hold so the pipeline backs up into in_stall
	always @(posedge clk) begin
		if (phase_num == HOLD_PHASE && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || headings_due.size() != 0);
	endtask

	task automatic write_declination(logic signed [chb_pkg::FIELD_W-1:0] v);
		@(posedge clk);
		cfg_valid            <= 1'b1;
		declination_centideg <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		decl_applied = v;
		decl_writes++;
		@(negedge clk);
	endtask

	initial begin : run
		int          dir_x [24] = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768,
			32767, 1, -1, -1, 1, -1, 0, 0, 1, -32768, -32768, 32767, 32767, 3, -5, 100};
		int          dir_y [24] = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767,
			-32768, 1, 1, -1, -1, 0, 1, -1, 0, -1, 1, 1, -1, 4, 12, -100};
		int          decl_list [N_PHASES] = '{0, 18000, -18000, 32767, -32768, 1, -1,
			9000, -4500, 0};
		mag_sample_t s;
		int          p, n;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (p = 0; p < N_PHASES; p++) begin
			send_mode = idle_mode_t'(p % 3);
			recv_mode = idle_mode_t'((p + 1) % 3);
			if (p == N_PHASES - 1)
				decl_list[p] = int'($urandom_range(0, 36000)) - 18000;
			if (p != 0)
				write_declination(16'(decl_list[p]));
			phase_num = p;
			if (p == 0) begin
				for (n = 0; n < 24; n++) begin
					s.x   = 16'(dir_x[n]);
					s.y   = 16'(dir_y[n]);
					s.gap = draw_wait(send_mode);
					samples_to_send.push_back(s);
				end
			end else begin
				for (n = 0; n < PHASE_BEATS; n++)
					samples_to_send.push_back(random_sample(send_mode));
			end
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(negedge clk);
		$display("Sent %0d samples, checked %0d headings across %0d declination writes,",
			beats_in, beats_out, decl_writes);
		$display("with random gaps on both sides and one %0d-cycle output hold.", HOLD_CYCLES);
		if (errors == 0 && headings_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
